// ----- hdl/pfla_pkg.sv -----
// Shared types and constants for the page free-list allocator.
// Used by pfla_ctrl, pfla_dp and the page_free_list_allocator top level.
// No dependencies.
package pfla_pkg;

   // Sizing
   localparam int MAX_PAGES = 1024;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CNT_W     = PAGE_W + 1;
   localparam int IDX_W     = 12;
   localparam int LINK_W    = 12;

   // Link word codes
   localparam logic [LINK_W-1:0] LINK_USED = {{(LINK_W-1){1'b1}}, 1'b0};
   localparam logic [LINK_W-1:0] LINK_END  = {LINK_W{1'b1}};

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_DISPOSE = 3'd1,
      OP_GET     = 3'd2,
      OP_NEXT    = 3'd3,
      OP_PREV    = 3'd4,
      OP_FLUSH   = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_CLOSED       = 3'd1,
      ST_INVALID      = 3'd2,
      ST_ALREADY_FREE = 3'd3,
      ST_NOT_IN_USE   = 3'd4,
      ST_NONE_FOUND   = 3'd5,
      ST_FULL         = 3'd6
   } status_type;

   // Link memory read address source
   typedef enum logic [1:0] {
      RD_NONE,
      RD_HEAD,
      RD_PAGE,
      RD_SCAN
   } rdsel_type;

   // State update applied when an operation finishes
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_POP,
      ACT_EXTEND,
      ACT_PUSH,
      ACT_CLEAN
   } act_type;

   // Source of the reported page number
   typedef enum logic [2:0] {
      PG_ZERO,
      PG_HEAD,
      PG_HW,
      PG_REQ,
      PG_PEND
   } pgsel_type;

   typedef struct packed {
      logic [2:0]              opcode;
      logic signed [IDX_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] result_page;
      logic [2:0]        status;
      logic [CNT_W-1:0]  page_count;
      logic              header_dirty;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      rdsel_type  rd_sel;
      logic       scan_init;
      logic       finish;
      act_type    act;
      status_type status;
      pgsel_type  pg_sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       open;
      logic       page_ok;
      logic       next_ok;
      logic       prev_ok;
      logic       head_ok;
      logic       full;
      logic       link_used;
      logic       scan_hit;
      logic       scan_end;
   } flags_type;

endpackage

// ----- hdl/pfla_ctrl.sv -----
// Sequencing state machine for the page free-list allocator.
// Decodes each request beat, drives datapath commands, owns the handshakes.
// Depends on pfla_pkg.
module pfla_ctrl import pfla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   input  flags_type flags,
   output cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_SCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Handshakes follow the state
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.rd_sel    = RD_NONE;
      cmd.scan_init = 1'b0;
      cmd.finish    = 1'b0;
      cmd.act       = ACT_NONE;
      cmd.status    = ST_OK;
      cmd.pg_sel    = PG_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!flags.open) begin
               cmd.finish = 1'b1;
               cmd.status = ST_CLOSED;
               state_in   = S_RESP;
            end else begin
               case (flags.op)
                  OP_ALLOC: begin
                     if (flags.head_ok) begin
                        cmd.rd_sel = RD_HEAD;
                        state_in   = S_LOOKUP;
                     end else if (flags.full) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_FULL;
                        state_in   = S_RESP;
                     end else begin
                        cmd.finish = 1'b1;
                        cmd.act    = ACT_EXTEND;
                        cmd.pg_sel = PG_HW;
                        state_in   = S_RESP;
                     end
                  end
                  OP_DISPOSE, OP_GET: begin
                     if (flags.page_ok) begin
                        cmd.rd_sel = RD_PAGE;
                        state_in   = S_LOOKUP;
                     end else begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_INVALID;
                        state_in   = S_RESP;
                     end
                  end
                  OP_NEXT, OP_PREV: begin
                     if ((flags.op == OP_NEXT) ? flags.next_ok : flags.prev_ok) begin
                        cmd.scan_init = 1'b1;
                        state_in      = S_SCAN;
                     end else begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_INVALID;
                        state_in   = S_RESP;
                     end
                  end
                  OP_FLUSH: begin
                     cmd.finish = 1'b1;
                     cmd.act    = ACT_CLEAN;
                     state_in   = S_RESP;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_INVALID;
                     state_in   = S_RESP;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            // Link word of the target page is in the read register
            cmd.finish = 1'b1;
            state_in   = S_RESP;
            case (flags.op)
               OP_ALLOC: begin
                  cmd.act    = ACT_POP;
                  cmd.pg_sel = PG_HEAD;
               end
               OP_DISPOSE: begin
                  if (flags.link_used) begin
                     cmd.act    = ACT_PUSH;
                     cmd.pg_sel = PG_REQ;
                  end else begin
                     cmd.status = ST_ALREADY_FREE;
                  end
               end
               OP_GET: begin
                  if (flags.link_used) begin
                     cmd.pg_sel = PG_REQ;
                  end else begin
                     cmd.status = ST_NOT_IN_USE;
                  end
               end
               default: begin
                  cmd.status = ST_INVALID;
               end
            endcase
         end
         S_SCAN: begin
            // One link read issued per cycle, checked in the next cycle
            cmd.rd_sel = RD_SCAN;
            if (flags.scan_hit) begin
               cmd.finish = 1'b1;
               cmd.pg_sel = PG_PEND;
               state_in   = S_RESP;
            end else if (flags.scan_end) begin
               cmd.finish = 1'b1;
               cmd.status = ST_NONE_FOUND;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/pfla_dp.sv -----
// Datapath for the page free-list allocator: link-word memory, header
// registers, scan counters and the response register.
// Depends on pfla_pkg.
module pfla_dp import pfla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  req_type   req_payload,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   input  cmd_type   cmd,
   output flags_type flags,
   output rsp_type   rsp_payload
);

   logic [LINK_W-1:0] mem [MAX_PAGES];

   logic              file_open_ff;
   logic [2:0]        op_ff;
   logic [IDX_W-1:0]  pidx_ff;
   logic [IDX_W-1:0]  pidx_inc;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;
   logic              dirty_ff, dirty_in;
   logic [LINK_W-1:0] rd_data_ff;
   logic [PAGE_W-1:0] rd_addr;
   logic              rd_en;
   logic              mem_we;
   logic [PAGE_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic [PAGE_W-1:0] scan_addr_ff, scan_addr_in;
   logic [PAGE_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              pend_vld_ff, pend_vld_in;
   logic              issue;
   logic              page_ok;
   logic [PAGE_W-1:0] res_page;
   rsp_type           rsp_ff;

   // Status back to the controller
   assign page_ok = !pidx_ff[IDX_W-1] && (pidx_ff[CNT_W-1:0] < hw_ff);

   always_comb begin
      flags.op        = op_ff;
      flags.open      = file_open_ff;
      flags.page_ok   = page_ok;
      flags.next_ok   = (pidx_ff == {IDX_W{1'b1}}) || page_ok;
      flags.prev_ok   = (!pidx_ff[IDX_W-1] && (pidx_ff[CNT_W-1:0] == hw_ff)) || page_ok;
      flags.head_ok   = !head_ff[LINK_W-1] && (head_ff[CNT_W-1:0] < hw_ff);
      flags.full      = (hw_ff >= CNT_W'(MAX_PAGES));
      flags.link_used = (rd_data_ff == LINK_USED);
      flags.scan_hit  = pend_vld_ff && (rd_data_ff == LINK_USED);
      flags.scan_end  = !pend_vld_ff && (scan_cnt_ff == '0);
   end

   // Read address select
   assign issue = (cmd.rd_sel == RD_SCAN) && (scan_cnt_ff != '0);

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_ff[PAGE_W-1:0];
         RD_PAGE: rd_addr = pidx_ff[PAGE_W-1:0];
         RD_SCAN: rd_addr = scan_addr_ff;
         default: rd_addr = '0;
      endcase
      rd_en = (cmd.rd_sel == RD_HEAD) || (cmd.rd_sel == RD_PAGE) || issue;
   end

   // Scan address, remaining count and in-flight read tag
   assign pidx_inc = pidx_ff + 1'b1;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      scan_cnt_in  = scan_cnt_ff;
      pend_addr_in = pend_addr_ff;
      pend_vld_in  = pend_vld_ff;
      if (cmd.scan_init) begin
         pend_vld_in = 1'b0;
         if (op_ff == OP_NEXT) begin
            scan_addr_in = pidx_inc[PAGE_W-1:0];
            scan_cnt_in  = hw_ff - pidx_inc[CNT_W-1:0];
         end else begin
            scan_addr_in = pidx_ff[PAGE_W-1:0] - 1'b1;
            scan_cnt_in  = pidx_ff[CNT_W-1:0];
         end
      end else if (issue) begin
         pend_vld_in  = 1'b1;
         pend_addr_in = scan_addr_ff;
         scan_cnt_in  = scan_cnt_ff - 1'b1;
         if (op_ff == OP_NEXT) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end else begin
            scan_addr_in = scan_addr_ff - 1'b1;
         end
      end else if (cmd.rd_sel == RD_SCAN) begin
         pend_vld_in = 1'b0;
      end
   end

   // Header update and link write on finish
   always_comb begin
      mem_we   = 1'b0;
      wr_addr  = head_ff[PAGE_W-1:0];
      wr_data  = LINK_USED;
      head_in  = head_ff;
      hw_in    = hw_ff;
      dirty_in = dirty_ff;
      if (cmd.finish) begin
         case (cmd.act)
            ACT_POP: begin
               mem_we   = 1'b1;
               head_in  = rd_data_ff;
               dirty_in = 1'b1;
            end
            ACT_EXTEND: begin
               mem_we   = 1'b1;
               wr_addr  = hw_ff[PAGE_W-1:0];
               hw_in    = hw_ff + 1'b1;
               dirty_in = 1'b1;
            end
            ACT_PUSH: begin
               mem_we   = 1'b1;
               wr_addr  = pidx_ff[PAGE_W-1:0];
               wr_data  = head_ff;
               head_in  = pidx_ff;
               dirty_in = 1'b1;
            end
            ACT_CLEAN: begin
               dirty_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Reported page
   always_comb begin
      case (cmd.pg_sel)
         PG_HEAD: res_page = head_ff[PAGE_W-1:0];
         PG_HW:   res_page = hw_ff[PAGE_W-1:0];
         PG_REQ:  res_page = pidx_ff[PAGE_W-1:0];
         PG_PEND: res_page = pend_addr_ff;
         default: res_page = '0;
      endcase
   end

   // Link-word memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control and header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         file_open_ff <= 1'b0;
         head_ff      <= LINK_END;
         hw_ff        <= '0;
         dirty_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            file_open_ff <= csr_wr_data;
         end
         head_ff     <= head_in;
         hw_ff       <= hw_in;
         dirty_ff    <= dirty_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_payload.opcode;
         pidx_ff <= req_payload.page_index;
      end
      scan_addr_ff <= scan_addr_in;
      scan_cnt_ff  <= scan_cnt_in;
      pend_addr_ff <= pend_addr_in;
      if (cmd.finish) begin
         rsp_ff.result_page  <= res_page;
         rsp_ff.status       <= cmd.status;
         rsp_ff.page_count   <= hw_in;
         rsp_ff.header_dirty <= dirty_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- hdl/page_free_list_allocator.sv -----
// Page free-list allocator top level: controller plus datapath.
// Closed, invalid, full, extend and flush requests are answered from the decode state;
// free-list allocate, dispose and get add a link-memory lookup; next/prev scans read one
// link word per page visited until a used page is found or the range is exhausted.
// One request at a time; the next beat is taken the cycle after the response is taken.
// Synchronous active-high reset: closed file, empty free list, zero pages, header clean.
module page_free_list_allocator import pfla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   cmd_type   cmd;
   flags_type flags;

   // Sequencer
   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   pfla_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .flags       (flags),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sim/tb_page_free_list_allocator.sv -----
// Self-checking testbench for page_free_list_allocator: directed table plus random traffic.
// A local predictor of the page bookkeeping supplies the expected responses.
// Depends on pfla_pkg and the page_free_list_allocator RTL.
module tb_page_free_list_allocator;
   import pfla_pkg::*;

   localparam int          CYCLE_LIMIT = 10_000_000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          SMALL_CAP   = 40;
   localparam logic [2:0]  OP_RSVD6    = 3'd6;
   localparam logic [2:0]  OP_RSVD7    = 3'd7;

   // Idle mix per phase: none, sender only, receiver only, both
   localparam int TX_PCT [4] = '{0, 76, 0, 31};
   localparam int RX_PCT [4] = '{0, 0, 76, 31};
   localparam bit PHASE_OPEN [8] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

   typedef enum bit [1:0] {ROW_CFG, ROW_FIXED, ROW_PRED} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [2:0]              op;
      logic signed [IDX_W-1:0] idx;
      rsp_type                 want;
   } plan_row_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Predictor state
   logic [LINK_W-1:0]       page_link [MAX_PAGES];
   logic signed [IDX_W-1:0] list_head    = LINK_END;
   logic [CNT_W-1:0]        pages_high   = '0;
   bit                      hdr_dirty    = 1'b0;
   bit                      file_is_open = 1'b0;

   rsp_type pending_results [$];
   int      error_count  = 0;
   int      cycle_count  = 0;
   int      tx_idle_pct  = 0;
   int      rx_stall_pct = 0;
   bit      holding      = 1'b0;
   event    hold_start;

   page_free_list_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit in_range(int p);
      return p >= 0 && p < int'(pages_high);
   endfunction

   // Apply one request to the bookkeeping and return the response it produces
   function automatic rsp_type predict_page_op(req_type r);
      rsp_type    o;
      status_type st;
      int         p;
      int         pg;
      int         q;
      p  = int'(r.page_index);
      st = ST_OK;
      pg = 0;
      if (!file_is_open) begin
         st = ST_CLOSED;
      end else begin
         case (r.opcode)
            OP_ALLOC: begin
               if (list_head != LINK_END && in_range(int'(list_head))) begin
                  pg = int'(list_head);
                  list_head = page_link[pg];
                  page_link[pg] = LINK_USED;
                  hdr_dirty = 1'b1;
               end else if (int'(pages_high) >= MAX_PAGES) begin
                  st = ST_FULL;
               end else begin
                  pg = int'(pages_high);
                  pages_high = pages_high + 1'b1;
                  page_link[pg] = LINK_USED;
                  hdr_dirty = 1'b1;
               end
            end
            OP_DISPOSE: begin
               if (!in_range(p)) st = ST_INVALID;
               else if (page_link[p] != LINK_USED) st = ST_ALREADY_FREE;
               else begin
                  page_link[p] = list_head;
                  list_head = p[IDX_W-1:0];
                  hdr_dirty = 1'b1;
                  pg = p;
               end
            end
            OP_GET: begin
               if (!in_range(p)) st = ST_INVALID;
               else if (page_link[p] != LINK_USED) st = ST_NOT_IN_USE;
               else pg = p;
            end
            OP_NEXT: begin
               if (p != -1 && !in_range(p)) begin
                  st = ST_INVALID;
               end else begin
                  st = ST_NONE_FOUND;
                  for (q = p + 1; q < int'(pages_high); q++) begin
                     if (page_link[q] == LINK_USED) begin
                        pg = q;
                        st = ST_OK;
                        break;
                     end
                  end
               end
            end
            OP_PREV: begin
               // the page count itself starts the scan from the top
               if (p != int'(pages_high) && !in_range(p)) begin
                  st = ST_INVALID;
               end else begin
                  st = ST_NONE_FOUND;
                  for (q = p - 1; q >= 0; q--) begin
                     if (page_link[q] == LINK_USED) begin
                        pg = q;
                        st = ST_OK;
                        break;
                     end
                  end
               end
            end
            OP_FLUSH: hdr_dirty = 1'b0;
            default:  st = ST_INVALID;
         endcase
      end
      if (st != ST_OK) pg = 0;
      o.result_page  = pg[PAGE_W-1:0];
      o.status       = st;
      o.page_count   = pages_high;
      o.header_dirty = hdr_dirty;
      return o;
   endfunction

   // Random request; allocation turns into dispose once the file reaches hw_cap pages and the free list is empty
   function automatic req_type draw_request(int hw_cap);
      req_type r;
      int      roll;
      int      hw;
      int      pick;
      hw   = int'(pages_high);
      roll = $urandom_range(0, 99);
      if (roll >= 94) begin
         r.opcode     = 3'($urandom_range(0, 7));
         r.page_index = 12'($urandom);
         return r;
      end
      if (roll < 26) r.opcode = (hw >= hw_cap && list_head == LINK_END) ? OP_DISPOSE : OP_ALLOC;
      else if (roll < 50) r.opcode = OP_DISPOSE;
      else if (roll < 64) r.opcode = OP_GET;
      else if (roll < 76) r.opcode = OP_NEXT;
      else if (roll < 88) r.opcode = OP_PREV;
      else r.opcode = OP_FLUSH;
      roll = $urandom_range(0, 99);
      if (roll < 75 && hw > 0) begin
         pick = $urandom_range(0, hw - 1);
         // dispose and get mostly aim at used pages
         if (r.opcode == OP_DISPOSE || r.opcode == OP_GET) begin
            repeat (3) if (page_link[pick] != LINK_USED) pick = $urandom_range(0, hw - 1);
         end
         r.page_index = pick[IDX_W-1:0];
      end else if (roll < 88) begin
         r.page_index = IDX_W'((r.opcode == OP_PREV) ? hw : -1);
      end else begin
         r.page_index = 12'($urandom);
      end
      return r;
   endfunction

   function automatic plan_row_type fixed_row(logic [2:0] op, int idx, int pg, status_type st,
                                              int cnt, bit dirty);
      plan_row_type e;
      e.kind              = ROW_FIXED;
      e.op                = op;
      e.idx               = idx[IDX_W-1:0];
      e.want.result_page  = pg[PAGE_W-1:0];
      e.want.status       = st;
      e.want.page_count   = cnt[CNT_W-1:0];
      e.want.header_dirty = dirty;
      return e;
   endfunction

   function automatic plan_row_type pred_row(logic [2:0] op, int idx);
      plan_row_type e;
      e      = '0;
      e.kind = ROW_PRED;
      e.op   = op;
      e.idx  = idx[IDX_W-1:0];
      return e;
   endfunction

   function automatic plan_row_type cfg_row(bit open_val);
      plan_row_type e;
      e      = '0;
      e.kind = ROW_CFG;
      e.idx  = IDX_W'(open_val);
      return e;
   endfunction

   task automatic log_mismatch(string field, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // Offer one beat, honoring sender idling; called and returns at a falling edge
   task automatic send_item(req_type r, bit fixed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_page_op(r);
      pending_results.push_back(fixed ? want : predicted);
      @(negedge clock);
   endtask

   // Drain outstanding responses, let the block go idle, then write file_open
   task automatic settle_and_write(bit open_val);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= open_val;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      file_is_open = open_val;
   endtask

   // Receiver: random stalls, plus the long hold-off
   always @(negedge clock) begin
      rsp_ready <= !holding && ($urandom_range(0, 99) >= rx_stall_pct);
   end

   initial begin
      forever begin
         @(hold_start);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch("unexpected response page", int'(rsp_payload.result_page), -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.result_page !== want.result_page)
               log_mismatch("result_page", int'(rsp_payload.result_page),
                            int'(want.result_page));
            if (rsp_payload.status !== want.status)
               log_mismatch("status", int'(rsp_payload.status), int'(want.status));
            if (rsp_payload.page_count !== want.page_count)
               log_mismatch("page_count", int'(rsp_payload.page_count),
                            int'(want.page_count));
            if (rsp_payload.header_dirty !== want.header_dirty)
               log_mismatch("header_dirty", int'(rsp_payload.header_dirty),
                            int'(want.header_dirty));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      plan_row_type plan [$];
      req_type      r;

      // Directed table: closed file, empty file, small list traffic, bad indexes, reserved opcodes
      plan.push_back(fixed_row(OP_ALLOC,      0, 0, ST_CLOSED,       0, 0));
      plan.push_back(fixed_row(OP_GET,       -1, 0, ST_CLOSED,       0, 0));
      plan.push_back(cfg_row(1'b1));
      plan.push_back(fixed_row(OP_NEXT,      -1, 0, ST_NONE_FOUND,   0, 0));
      plan.push_back(fixed_row(OP_PREV,       0, 0, ST_NONE_FOUND,   0, 0));
      plan.push_back(fixed_row(OP_GET,        0, 0, ST_INVALID,      0, 0));
      plan.push_back(fixed_row(OP_ALLOC,      0, 0, ST_OK,           1, 1));
      plan.push_back(pred_row(OP_ALLOC, 0));
      plan.push_back(pred_row(OP_ALLOC, 0));
      plan.push_back(pred_row(OP_FLUSH, 0));
      plan.push_back(pred_row(OP_DISPOSE, 1));
      plan.push_back(fixed_row(OP_DISPOSE,    1, 0, ST_ALREADY_FREE, 3, 1));
      plan.push_back(fixed_row(OP_GET,        1, 0, ST_NOT_IN_USE,   3, 1));
      plan.push_back(pred_row(OP_GET, 2));
      plan.push_back(pred_row(OP_NEXT, 0));
      plan.push_back(pred_row(OP_PREV, 3));
      plan.push_back(pred_row(OP_PREV, 2));
      plan.push_back(fixed_row(OP_NEXT,       2, 0, ST_NONE_FOUND,   3, 1));
      plan.push_back(fixed_row(OP_DISPOSE,   -1, 0, ST_INVALID,      3, 1));
      plan.push_back(fixed_row(OP_DISPOSE, 2047, 0, ST_INVALID,      3, 1));
      plan.push_back(fixed_row(OP_NEXT,   -2048, 0, ST_INVALID,      3, 1));
      plan.push_back(fixed_row(OP_PREV,       4, 0, ST_INVALID,      3, 1));
      plan.push_back(fixed_row(OP_RSVD6,      0, 0, ST_INVALID,      3, 1));
      plan.push_back(fixed_row(OP_RSVD7,     -1, 0, ST_INVALID,      3, 1));
      plan.push_back(pred_row(OP_ALLOC, 0));
      plan.push_back(cfg_row(1'b0));
      plan.push_back(fixed_row(OP_FLUSH,      0, 0, ST_CLOSED,       3, 1));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         r.opcode     = plan[i].op;
         r.page_index = plan[i].idx;
         case (plan[i].kind)
            ROW_CFG:   settle_and_write(plan[i].idx[0]);
            ROW_FIXED: send_item(r, 1'b1, plan[i].want);
            default:   send_item(r, 1'b0, '0);
         endcase
      end

      // Random phases on a small file, one of them under a long receiver hold-off
      for (int ph = 0; ph < 8; ph++) begin
         settle_and_write(PHASE_OPEN[ph]);
         tx_idle_pct  = TX_PCT[ph % 4];
         rx_stall_pct = RX_PCT[ph % 4];
         if (ph == 1) -> hold_start;
         repeat (PHASE_OPEN[ph] ? 75 : 20) send_item(draw_request(SMALL_CAP), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
